@@ rtl/core/sis_pkg.sv @@
`default_nettype none
package sis_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [COUNT_W-1:0]       count_t;

  // controller to datapath
  typedef struct packed {
    logic insert;   // place the arriving value in order
    logic drop;     // note a value lost to a full store
    logic shift;    // move the store one cell towards the head
    logic clear;    // forget the overflow mark
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic last_one; // a single value left in the store
  } status_t;

endpackage
`default_nettype wire

@@ rtl/core/sis_dpath.sv @@
`default_nettype none
module sis_dpath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sis_pkg::cmd_t    cmd,
  input  wire sis_pkg::data_t   value,
  output sis_pkg::status_t      status,
  output sis_pkg::data_t        head,
  output logic                  dropped
);

  sis_pkg::data_t  cells [sis_pkg::MAX_ITEMS];
  sis_pkg::data_t  ins_next [sis_pkg::MAX_ITEMS];
  sis_pkg::count_t count;
  logic [sis_pkg::MAX_ITEMS-1:0] gt;

  // every held cell compares against the new value at once
  always_comb begin
    for (int i = 0; i < sis_pkg::MAX_ITEMS; i++) begin
      gt[i] = (sis_pkg::COUNT_W'(i) < count) && (cells[i] > value);
    end
    for (int i = 0; i < sis_pkg::MAX_ITEMS; i++) begin
      if (i > 0 && gt[i-1 < 0 ? 0 : i-1]) begin
        ins_next[i] = cells[i-1 < 0 ? 0 : i-1];
      end else if (gt[i] || sis_pkg::COUNT_W'(i) == count) begin
        ins_next[i] = value;
      end else begin
        ins_next[i] = cells[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < sis_pkg::MAX_ITEMS; i++) cells[i] <= ins_next[i];
    end else if (cmd.shift) begin
      for (int i = 0; i < sis_pkg::MAX_ITEMS - 1; i++) cells[i] <= cells[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count + 1'b1;
      end else if (cmd.shift) begin
        count <= count - 1'b1;
      end
      if (cmd.drop) begin
        dropped <= 1'b1;
      end else if (cmd.clear) begin
        dropped <= 1'b0;
      end
    end
  end

  assign status.full     = (count == sis_pkg::COUNT_W'(sis_pkg::MAX_ITEMS));
  assign status.last_one = (count == sis_pkg::COUNT_W'(1));
  assign head            = cells[0];

endmodule
`default_nettype wire

@@ rtl/core/sis_ctrl.sv @@
`default_nettype none
module sis_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             last,
  input  wire sis_pkg::status_t status,
  output sis_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  emit
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.insert = !status.full;
          cmd.drop   = status.full;
          if (last) state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.shift = 1'b1;
        if (status.last_one) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state == ST_EMIT);
  assign emit = (state == ST_EMIT);

endmodule
`default_nettype wire

@@ rtl/core/stable_insertion_sort_core.sv @@
`default_nettype none
// Stable insertion sort of signed Q16.16 values, up to MAX_ITEMS per set.
// Input: drive value and last with start; a transaction is taken at a rising
// edge with start high and busy low. Values that are not marked last may
// follow back to back; each is placed in order by a row of cells that all
// compare against it at once, behind any equal value. A value arriving when
// the store is full is dropped and the set is marked. The transaction with
// last high closes the set: busy rises in the next cycle and the store shifts
// out one value per cycle from its head until it is empty, during which start
// is ignored. Each result shows on sorted_value with strobe high for one
// cycle; end_of_set marks the final one, overflow marks every result of a set
// that lost values. The receiver cannot stall. After the final result busy
// falls and the next set may begin.
// Reset (rst, synchronous) empties the store and clears the overflow mark.
module stable_insertion_sort_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire sis_pkg::data_t value,
  input  wire logic           last,
  output logic                strobe,
  output sis_pkg::data_t      sorted_value,
  output logic                end_of_set,
  output logic                overflow
);

  sis_pkg::cmd_t    cmd;
  sis_pkg::status_t status;
  logic             dropped;

  sis_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .emit   (strobe)
  );

  sis_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .value   (value),
    .status  (status),
    .head    (sorted_value),
    .dropped (dropped)
  );

  assign end_of_set = strobe && status.last_one;
  assign overflow   = dropped;

  a_close_emits: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last |=> strobe)
    else $error("closing transaction not followed by a result");

  a_end_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && end_of_set |=> !busy)
    else $error("busy held after final result");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !end_of_set |=> strobe && overflow == $past(overflow))
    else $error("result burst broken or overflow changed mid-set");

endmodule
`default_nettype wire
